>>> design/svpwm_pkg.sv
// ----------------------------------------------------------------------------
// svpwm_pkg
// Shared types, constants and the sine table of the SVPWM duty generator.
// ----------------------------------------------------------------------------
package svpwm_pkg;

   localparam int SineTableDepth = 1024;

   // angle formats, Q16.16 and Q30
   localparam longint SectorQ16 = 68629;
   localparam longint TurnQ16   = 6 * SectorQ16;
   localparam longint TurnQ30   = 64'sd6746518852;
   localparam longint OneQ30    = 64'sd1 << 30;

   // angle wrap: shift to a positive value, then reciprocal multiply
   localparam longint TurnOffset  = ((64'sd1 << 31) + TurnQ16 - 1) / TurnQ16 * TurnQ16;
   localparam int     OffsetW     = 33;
   localparam int     ModPreShift = 13;
   localparam int     ModShift    = 24;
   localparam int     ModInW      = OffsetW - ModPreShift;
   localparam longint ModRecip    = (64'sd1 << (ModPreShift + ModShift)) / TurnQ16;
   localparam int     ModRecipW   = $clog2(ModRecip + 1);
   localparam int     QuotW       = 14;
   localparam int     RemRawW     = 20;
   localparam int     AngleW      = 19;
   localparam int     SubAngleW   = 17;
   localparam int     SectorW     = 3;

   // sine table index and lookup
   localparam int     SineEntries = int'(SectorQ16 * SineTableDepth / TurnQ16) + 1;
   localparam int     IdxW        = $clog2(SineEntries);
   localparam int     IdxShift    = 32;
   localparam longint IdxRecip    = (longint'(SineTableDepth) << IdxShift) / TurnQ16;
   localparam int     IdxRecipW   = $clog2(IdxRecip + 1);
   localparam int     IdxProdW    = SubAngleW + IdxRecipW;
   localparam int     IdxMulW     = SubAngleW + $clog2(SineTableDepth) + 1;
   localparam int     SineW       = 15;

   // configuration
   localparam int SupplyW     = 15;
   localparam int LimitW      = 15;
   localparam int PeriodW     = 16;
   localparam int CsrDataW    = 16;
   localparam int VoltW       = 16;
   localparam int ProdW       = 32;
   localparam int DivSteps    = PeriodW;
   localparam int NumW        = SupplyW + DivSteps;

   localparam logic [SupplyW-1:0] SupplyReset = 15'd3072;
   localparam logic [LimitW-1:0]  LimitReset  = 15'd3072;
   localparam logic [PeriodW-1:0] PeriodReset = 16'd3599;

   // pipeline stage numbers
   localparam int StageAngle = 5;
   localparam int StageSine  = StageAngle + 3;
   localparam int StageProd  = StageSine + 1;
   localparam int StageSel   = StageProd + 1;
   localparam int StageLast  = StageSel + 2 + DivSteps;

   typedef enum logic [1:0] {
      CSR_SUPPLY_VOLTAGE = 2'd0,
      CSR_VOLTAGE_LIMIT  = 2'd1,
      CSR_PWM_PERIOD     = 2'd2,
      CSR_RESERVED       = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [SectorW-1:0]   sector;
      logic [SubAngleW-1:0] t1;
      logic [SubAngleW-1:0] t2;
   } angle_type;

   typedef struct packed {
      logic [PeriodW-1:0] compare_a;
      logic [PeriodW-1:0] compare_b;
      logic [PeriodW-1:0] compare_c;
      logic [SectorW-1:0] sector_number;
      logic               voltage_clamped;
   } result_type;

   typedef logic [SineW-1:0] sine_rom_type [SineEntries];

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      longint x;
      longint x2;
      longint term;
      longint sum;
      for (int k = 0; k < SineEntries; k++) begin
         x    = (longint'(k) * TurnQ30) / SineTableDepth;
         x2   = (x * x) >> 30;
         sum  = x;
         term = ((x * x2) >> 30) / 6;
         sum  = sum - term;
         term = ((term * x2) >> 30) / 20;
         sum  = sum + term;
         term = ((term * x2) >> 30) / 42;
         sum  = sum - term;
         term = ((term * x2) >> 30) / 72;
         sum  = sum + term;
         if (sum < 0) begin
            sum = 0;
         end
         rom[k] = SineW'((sum * 32767 + OneQ30 / 2) / OneQ30);
      end
      return rom;
   endfunction

   localparam sine_rom_type SineRom = build_sine_rom();

endpackage

>>> design/svpwm_if.sv
// ----------------------------------------------------------------------------
// svpwm_req_if / svpwm_rsp_if
// Valid/ready channels carrying command words and result words.
// ----------------------------------------------------------------------------
interface svpwm_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] voltage_command;
   logic signed [31:0] drive_angle;

   modport source (output valid, output voltage_command, output drive_angle,
                   input ready);
   modport sink   (input valid, input voltage_command, input drive_angle,
                   output ready);
endinterface

interface svpwm_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] compare_a;
   logic [15:0] compare_b;
   logic [15:0] compare_c;
   logic [2:0]  sector_number;
   logic        voltage_clamped;

   modport source (output valid, output compare_a, output compare_b, output compare_c,
                   output sector_number, output voltage_clamped, input ready);
   modport sink   (input valid, input compare_a, input compare_b, input compare_c,
                   input sector_number, input voltage_clamped, output ready);
endinterface

>>> design/svpwm_duty_generator.sv
// ----------------------------------------------------------------------------
// svpwm_duty_generator
// Space vector PWM: voltage command and electrical angle to three compares.
// ----------------------------------------------------------------------------
// Takes one command word per clock while the skid slot is empty and returns
// one result word per command, in order. The depth is set by the per-phase
// compare divide (one quotient bit per stage, sixteen stages) behind the
// angle wrap, sine lookup and duty multiply. An output register with a skid
// slot keeps req_word.ready high while one result waits; write the
// configuration only while no word is in flight.
module svpwm_duty_generator import svpwm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   svpwm_req_if.sink             req_word,
   svpwm_rsp_if.source           rsp_word,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  logic [CsrDataW-1:0]   csr_wdata
);

   logic [SupplyW-1:0] supply_ff;
   logic [LimitW-1:0]  limit_ff;
   logic [PeriodW-1:0] period_ff;
   logic [SupplyW-1:0] divisor;

   logic adv;
   logic [StageLast:1]     valid_ff;
   logic [StageLast:1]     clamp_ff;
   logic signed [VoltW-1:0] volt_ff [1:StageSine];
   logic [SectorW-1:0]     sector_ff [StageAngle+1:StageLast];

   logic signed [16:0]     cmd_ext;
   logic signed [16:0]     lim_ext;
   logic signed [VoltW-1:0] volt_in;
   logic                   clamp_in;

   angle_type              angle;
   logic [SineW-1:0]       sine1;
   logic [SineW-1:0]       sine2;
   logic signed [ProdW-1:0] p1_ff;
   logic signed [ProdW-1:0] p2_ff;
   logic signed [ProdW-1:0] nsum;
   logic signed [ProdW-1:0] ndiff;
   logic signed [ProdW-1:0] na_in;
   logic signed [ProdW-1:0] nb_in;
   logic signed [ProdW-1:0] nc_in;
   logic signed [ProdW-1:0] na_ff;
   logic signed [ProdW-1:0] nb_ff;
   logic signed [ProdW-1:0] nc_ff;
   logic [PeriodW-1:0]     cmp_a;
   logic [PeriodW-1:0]     cmp_b;
   logic [PeriodW-1:0]     cmp_c;

   result_type tail;
   result_type out_ff;
   result_type skid_ff;
   logic       out_v_ff;
   logic       skid_v_ff;
   logic       push;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         supply_ff <= SupplyReset;
         limit_ff  <= LimitReset;
         period_ff <= PeriodReset;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SUPPLY_VOLTAGE: supply_ff <= csr_wdata[SupplyW-1:0];
            CSR_VOLTAGE_LIMIT:  limit_ff  <= csr_wdata[LimitW-1:0];
            CSR_PWM_PERIOD:     period_ff <= csr_wdata[PeriodW-1:0];
            default: ;
         endcase
      end
   end

   assign divisor = (supply_ff == '0) ? SupplyW'(1) : supply_ff;

   // clamp
   assign cmd_ext = {req_word.voltage_command[15], req_word.voltage_command};
   assign lim_ext = $signed({2'b00, limit_ff});

   always_comb begin
      volt_in  = req_word.voltage_command;
      clamp_in = 1'b0;
      if (cmd_ext > lim_ext) begin
         volt_in  = VoltW'(lim_ext);
         clamp_in = 1'b1;
      end else if (cmd_ext < -lim_ext) begin
         volt_in  = VoltW'(-lim_ext);
         clamp_in = 1'b1;
      end
   end

   svpwm_angle u_angle (
      .clock     (clock),
      .adv       (adv),
      .angle     (req_word.drive_angle),
      .angle_out (angle)
   );

   svpwm_sine u_sine1 (
      .clock     (clock),
      .adv       (adv),
      .sub_angle (angle.t1),
      .sine      (sine1)
   );

   svpwm_sine u_sine2 (
      .clock     (clock),
      .adv       (adv),
      .sub_angle (angle.t2),
      .sine      (sine2)
   );

   // sector table
   assign nsum  = p1_ff + p2_ff;
   assign ndiff = p1_ff - p2_ff;

   always_comb begin
      unique case (sector_ff[StageProd])
         3'd0: begin na_in = nsum;   nb_in = -ndiff; nc_in = -nsum;  end
         3'd1: begin na_in = ndiff;  nb_in = nsum;   nc_in = -nsum;  end
         3'd2: begin na_in = -nsum;  nb_in = nsum;   nc_in = -ndiff; end
         3'd3: begin na_in = -nsum;  nb_in = ndiff;  nc_in = nsum;   end
         3'd4: begin na_in = -ndiff; nb_in = -nsum;  nc_in = nsum;   end
         default: begin na_in = nsum; nb_in = -nsum; nc_in = ndiff;  end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         clamp_ff[1] <= clamp_in;
         volt_ff[1]  <= volt_in;
         for (int k = 2; k <= StageLast; k++) begin
            clamp_ff[k] <= clamp_ff[k-1];
         end
         for (int k = 2; k <= StageSine; k++) begin
            volt_ff[k] <= volt_ff[k-1];
         end
         sector_ff[StageAngle+1] <= angle.sector;
         for (int k = StageAngle + 2; k <= StageLast; k++) begin
            sector_ff[k] <= sector_ff[k-1];
         end
         p1_ff <= $signed(ProdW'(sine1)) * ProdW'(volt_ff[StageSine]);
         p2_ff <= $signed(ProdW'(sine2)) * ProdW'(volt_ff[StageSine]);
         na_ff <= na_in;
         nb_ff <= nb_in;
         nc_ff <= nc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[StageLast-1:1], req_word.valid};
      end
   end

   svpwm_phase u_phase_a (
      .clock (clock), .adv (adv), .numer (na_ff), .divisor (divisor),
      .period (period_ff), .compare (cmp_a)
   );

   svpwm_phase u_phase_b (
      .clock (clock), .adv (adv), .numer (nb_ff), .divisor (divisor),
      .period (period_ff), .compare (cmp_b)
   );

   svpwm_phase u_phase_c (
      .clock (clock), .adv (adv), .numer (nc_ff), .divisor (divisor),
      .period (period_ff), .compare (cmp_c)
   );

   // output register and skid slot
   assign tail.compare_a       = cmp_a;
   assign tail.compare_b       = cmp_b;
   assign tail.compare_c       = cmp_c;
   assign tail.sector_number   = sector_ff[StageLast];
   assign tail.voltage_clamped = clamp_ff[StageLast];

   assign adv  = !skid_v_ff;
   assign push = adv && valid_ff[StageLast];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (out_v_ff && !rsp_word.ready) begin
            if (push) begin
               skid_v_ff <= 1'b1;
            end
         end else if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= push;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_v_ff && !rsp_word.ready) begin
         if (push) begin
            skid_ff <= tail;
         end
      end else if (skid_v_ff) begin
         out_ff <= skid_ff;
      end else if (push) begin
         out_ff <= tail;
      end
   end

   assign req_word.ready           = adv;
   assign rsp_word.valid           = out_v_ff;
   assign rsp_word.compare_a       = out_ff.compare_a;
   assign rsp_word.compare_b       = out_ff.compare_b;
   assign rsp_word.compare_c       = out_ff.compare_c;
   assign rsp_word.sector_number   = out_ff.sector_number;
   assign rsp_word.voltage_clamped = out_ff.voltage_clamped;

`ifndef SYNTH
   skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid slot full while output register empty");

   sector_range: assert property (@(posedge clock) disable iff (reset)
      rsp_word.valid |-> (rsp_word.sector_number <= 3'd5))
      else $error("sector number out of range");

   stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      (push && out_v_ff && !rsp_word.ready) |=> skid_v_ff)
      else $error("stalled word not held in skid slot");
`endif

endmodule

>>> design/svpwm_angle.sv
// ----------------------------------------------------------------------------
// svpwm_angle
// Five-stage angle wrap into one turn, sector split and sub-angles.
// ----------------------------------------------------------------------------
module svpwm_angle import svpwm_pkg::*; (
   input  logic               clock,
   input  logic               adv,
   input  logic signed [31:0] angle,
   output angle_type          angle_out
);

   logic [OffsetW-1:0]                 shifted_ff;
   logic [OffsetW-1:0]                 shifted2_ff;
   logic [QuotW-1:0]                   quot_ff;
   logic [ModInW+ModRecipW-1:0]        quot_prod;
   logic [OffsetW-1:0]                 rem_full;
   logic [RemRawW-1:0]                 rem_raw_ff;
   logic [AngleW-1:0]                  wrapped_ff;
   logic [AngleW-1:0]                  wrapped_in;
   logic [SectorW-1:0]                 sector_in;
   logic [AngleW-1:0]                  base_in;
   angle_type                          angle_ff;

   assign quot_prod = (ModInW + ModRecipW)'(shifted_ff[OffsetW-1:ModPreShift])
                      * (ModInW + ModRecipW)'(ModRecip);
   assign rem_full  = shifted2_ff - OffsetW'(quot_ff) * OffsetW'(TurnQ16);
   assign wrapped_in = (rem_raw_ff >= RemRawW'(TurnQ16))
                       ? AngleW'(rem_raw_ff - RemRawW'(TurnQ16))
                       : AngleW'(rem_raw_ff);

   always_comb begin
      sector_in = '0;
      base_in   = '0;
      for (int k = 1; k < 6; k++) begin
         if (wrapped_ff >= AngleW'(k * SectorQ16)) begin
            sector_in = SectorW'(k);
            base_in   = AngleW'(k * SectorQ16);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         shifted_ff      <= OffsetW'({angle[31], angle}) + OffsetW'(TurnOffset);
         shifted2_ff     <= shifted_ff;
         quot_ff         <= quot_prod[ModShift +: QuotW];
         rem_raw_ff      <= rem_full[RemRawW-1:0];
         wrapped_ff      <= wrapped_in;
         angle_ff.sector <= sector_in;
         angle_ff.t1     <= SubAngleW'(base_in + AngleW'(SectorQ16) - wrapped_ff);
         angle_ff.t2     <= SubAngleW'(wrapped_ff - base_in);
      end
   end

   assign angle_out = angle_ff;

endmodule

>>> design/svpwm_sine.sv
// ----------------------------------------------------------------------------
// svpwm_sine
// Three-stage sine lookup: table index by reciprocal, correction, table read.
// ----------------------------------------------------------------------------
module svpwm_sine import svpwm_pkg::*; (
   input  logic                 clock,
   input  logic                 adv,
   input  logic [SubAngleW-1:0] sub_angle,
   output logic [SineW-1:0]     sine
);

   logic [IdxProdW-1:0]  est_prod;
   logic [IdxW-1:0]      est_ff;
   logic [SubAngleW-1:0] sub_ff;
   logic [IdxMulW-1:0]   lhs;
   logic [IdxMulW-1:0]   rhs;
   logic [IdxW-1:0]      idx_ff;
   logic [SineW-1:0]     sine_ff;

   assign est_prod = IdxProdW'(sub_angle) * IdxProdW'(IdxRecip);
   assign lhs      = IdxMulW'(sub_ff) * IdxMulW'(SineTableDepth);
   assign rhs      = (IdxMulW'(est_ff) + IdxMulW'(1)) * IdxMulW'(TurnQ16);

   always_ff @(posedge clock) begin
      if (adv) begin
         est_ff  <= est_prod[IdxShift +: IdxW];
         sub_ff  <= sub_angle;
         idx_ff  <= (lhs >= rhs) ? est_ff + IdxW'(1) : est_ff;
         sine_ff <= SineRom[idx_ff];
      end
   end

   assign sine = sine_ff;

endmodule

>>> design/svpwm_phase.sv
// ----------------------------------------------------------------------------
// svpwm_phase
// One phase lane: duty numerator, saturation flags, period scaling and a
// pipelined restoring divide by the supply voltage.
// ----------------------------------------------------------------------------
module svpwm_phase import svpwm_pkg::*; (
   input  logic                     clock,
   input  logic                     adv,
   input  logic signed [ProdW-1:0]  numer,
   input  logic [SupplyW-1:0]       divisor,
   input  logic [PeriodW-1:0]       period,
   output logic [PeriodW-1:0]       compare
);

   logic signed [ProdW:0]   half;
   logic signed [ProdW:0]   sum_in;
   logic [ProdW-2:0]        sum_ff;
   logic                    lo_ff;
   logic                    hi_ff;
   logic [ProdW-1+PeriodW-1:0] scaled;
   logic [NumW-1:0]         num_ff;
   logic                    lo2_ff;
   logic                    hi2_ff;

   logic [SupplyW-1:0]  rem_src [DivSteps];
   logic [DivSteps-1:0] low_src [DivSteps];
   logic [DivSteps-1:0] quo_src [DivSteps];
   logic [DivSteps-1:0] lo_src;
   logic [DivSteps-1:0] hi_src;
   logic [SupplyW:0]    trial   [DivSteps];
   logic [SupplyW-1:0]  rem_in  [DivSteps];
   logic [DivSteps-1:0] quo_in  [DivSteps];
   logic [SupplyW-1:0]  rem_ff  [DivSteps];
   logic [DivSteps-1:0] low_ff  [DivSteps];
   logic [DivSteps-1:0] quo_ff  [DivSteps];
   logic [DivSteps-1:0] lo_ff_q;
   logic [DivSteps-1:0] hi_ff_q;

   assign half   = $signed({3'b000, divisor, 15'b0});
   assign sum_in = $signed({numer[ProdW-1], numer}) + half;
   assign scaled = (ProdW + PeriodW - 1)'(sum_ff) * (ProdW + PeriodW - 1)'(period);

   always_comb begin
      rem_src[0] = num_ff[NumW-1:DivSteps];
      low_src[0] = num_ff[DivSteps-1:0];
      quo_src[0] = '0;
      lo_src[0]  = lo2_ff;
      hi_src[0]  = hi2_ff;
      for (int j = 1; j < DivSteps; j++) begin
         rem_src[j] = rem_ff[j-1];
         low_src[j] = low_ff[j-1];
         quo_src[j] = quo_ff[j-1];
         lo_src[j]  = lo_ff_q[j-1];
         hi_src[j]  = hi_ff_q[j-1];
      end
      for (int j = 0; j < DivSteps; j++) begin
         trial[j]  = {rem_src[j], low_src[j][DivSteps-1-j]};
         quo_in[j] = quo_src[j];
         if (trial[j] >= {1'b0, divisor}) begin
            rem_in[j]                 = SupplyW'(trial[j] - {1'b0, divisor});
            quo_in[j][DivSteps-1-j]   = 1'b1;
         end else begin
            rem_in[j] = trial[j][SupplyW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff <= sum_in[ProdW-2:0];
         lo_ff  <= sum_in[ProdW] || (sum_in == '0);
         hi_ff  <= $signed({numer[ProdW-1], numer}) >= half;
         num_ff <= scaled[ProdW-1+PeriodW-1:PeriodW];
         lo2_ff <= lo_ff;
         hi2_ff <= hi_ff;
         for (int j = 0; j < DivSteps; j++) begin
            rem_ff[j]  <= rem_in[j];
            low_ff[j]  <= low_src[j];
            quo_ff[j]  <= quo_in[j];
            lo_ff_q[j] <= lo_src[j];
            hi_ff_q[j] <= hi_src[j];
         end
      end
   end

   assign compare = hi_ff_q[DivSteps-1] ? period
                  : (lo_ff_q[DivSteps-1] ? '0 : quo_ff[DivSteps-1]);

endmodule

>>> tb/sv/svpwm_duty_generator_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// svpwm_duty_generator_checker
// Watches the command and result channels and computes the expected compare
// counts, sector and clamp flag of every accepted command word. It follows the
// configuration port and compares each result word, in order, against the
// oldest expected result.
// ----------------------------------------------------------------------------
module svpwm_duty_generator_checker import svpwm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   svpwm_req_if                req_word,
   svpwm_rsp_if                rsp_word,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   output int                  mismatch_count,
   output int                  pending_count
);

   localparam longint SectorLen  = 68629;
   localparam longint TurnLen    = 6 * SectorLen;
   localparam longint TwoPiQ30   = 64'sd6746518852;
   localparam longint UnityQ30   = 64'sd1 << 30;
   localparam int     TableDepth = 1024;

   logic [14:0] supply_reg;
   logic [14:0] limit_reg;
   logic [15:0] period_reg;
   result_type  expected_words[$];

   function automatic longint sine_lookup(longint sub_angle);
      longint k;
      longint x;
      longint x2;
      longint term;
      longint sum;
      k    = (sub_angle * TableDepth) / TurnLen;
      x    = (k * TwoPiQ30) / TableDepth;
      x2   = (x * x) >>> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 4; n++) begin
         term = ((term * x2) >>> 30) / (longint'(2 * n) * longint'(2 * n + 1));
         if (n % 2 == 1) begin
            sum -= term;
         end else begin
            sum += term;
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      return (sum * 32767 + UnityQ30 / 2) / UnityQ30;
   endfunction

   function automatic logic [15:0] duty_count(longint n, longint d, longint period);
      longint num;
      longint q;
      num = period * (d + n);
      if (num <= 0) begin
         return 16'd0;
      end
      q = num / (2 * d);
      if (q > period) begin
         q = period;
      end
      return 16'(q);
   endfunction

   function automatic result_type predict_duties(logic signed [15:0] volts,
                                                 logic signed [31:0] angle);
      result_type res;
      longint u;
      longint lim;
      longint sup;
      longint per;
      longint r;
      longint s;
      longint p1;
      longint p2;
      longint d;
      longint nsum;
      longint ndiff;
      longint na;
      longint nb;
      longint nc;
      u   = longint'(volts);
      lim = longint'(limit_reg);
      sup = (supply_reg == 0) ? 1 : longint'(supply_reg);
      per = longint'(period_reg);
      res.voltage_clamped = 1'b0;
      if (u > lim) begin
         u = lim;
         res.voltage_clamped = 1'b1;
      end
      if (u < -lim) begin
         u = -lim;
         res.voltage_clamped = 1'b1;
      end
      r = longint'(angle) % TurnLen;
      if (r < 0) begin
         r += TurnLen;
      end
      s = r / SectorLen;
      if (s > 5) begin
         s = 5;
      end
      p1    = sine_lookup(SectorLen * (s + 1) - r) * u;
      p2    = sine_lookup(r - SectorLen * s) * u;
      d     = 32768 * sup;
      nsum  = p1 + p2;
      ndiff = p1 - p2;
      case (s)
         0: begin na = nsum;   nb = -ndiff; nc = -nsum;  end
         1: begin na = ndiff;  nb = nsum;   nc = -nsum;  end
         2: begin na = -nsum;  nb = nsum;   nc = -ndiff; end
         3: begin na = -nsum;  nb = ndiff;  nc = nsum;   end
         4: begin na = -ndiff; nb = -nsum;  nc = nsum;   end
         default: begin na = nsum; nb = -nsum; nc = ndiff; end
      endcase
      res.compare_a     = duty_count(na, d, per);
      res.compare_b     = duty_count(nb, d, per);
      res.compare_c     = duty_count(nc, d, per);
      res.sector_number = 3'(s);
      return res;
   endfunction

   assign pending_count = expected_words.size();

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         supply_reg     <= 15'd3072;
         limit_reg      <= 15'd3072;
         period_reg     <= 16'd3599;
         mismatch_count <= 0;
         expected_words.delete();
      end else begin
         if (req_word.valid && req_word.ready) begin
            expected_words.push_back(predict_duties(req_word.voltage_command,
                                                    req_word.drive_angle));
         end
         if (rsp_word.valid && rsp_word.ready) begin
            got.compare_a       = rsp_word.compare_a;
            got.compare_b       = rsp_word.compare_b;
            got.compare_c       = rsp_word.compare_c;
            got.sector_number   = rsp_word.sector_number;
            got.voltage_clamped = rsp_word.voltage_clamped;
            if (expected_words.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("unexpected result word a=%0d b=%0d c=%0d s=%0d cl=%0b",
                           got.compare_a, got.compare_b, got.compare_c,
                           got.sector_number, got.voltage_clamped);
               end
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_words.pop_front();
               if (got !== want) begin
                  if (mismatch_count < 10) begin
                     $display("expected a=%0d b=%0d c=%0d s=%0d cl=%0b",
                              want.compare_a, want.compare_b, want.compare_c,
                              want.sector_number, want.voltage_clamped);
                     $display("  actual a=%0d b=%0d c=%0d s=%0d cl=%0b",
                              got.compare_a, got.compare_b, got.compare_c,
                              got.sector_number, got.voltage_clamped);
                  end
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SUPPLY_VOLTAGE: supply_reg <= csr_wdata[14:0];
               CSR_VOLTAGE_LIMIT:  limit_reg  <= csr_wdata[14:0];
               CSR_PWM_PERIOD:     period_reg <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

endmodule

>>> tb/sv/svpwm_duty_generator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// svpwm_duty_generator_test
// Drives command words through the duty generator in several register
// settings, extremes included: directed corner words first, then random
// words with random idle bursts on both channels except in the final calm
// stretch. The checker does the prediction; this module gives the verdict.
// ----------------------------------------------------------------------------
module svpwm_duty_generator_test;
   import svpwm_pkg::*;

   localparam int IdleLimit  = 2000;
   localparam int DrainDelay = 40;
   localparam longint TurnLen = 6 * 68629;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [1:0]          csr_index;
   logic [CsrDataW-1:0] csr_wdata;
   int                  mismatch_count;
   int                  pending_count;
   int                  idle_cycles;
   bit                  calm_mode;

   svpwm_req_if req_word ();
   svpwm_rsp_if rsp_word ();

   svpwm_duty_generator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .rsp_word  (rsp_word),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   svpwm_duty_generator_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_word       (req_word),
      .rsp_word       (rsp_word),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // result side stalls in random bursts
   always @(posedge clock) begin
      int stall;
      if (reset || calm_mode) begin
         rsp_word.ready <= 1'b1;
      end else if (rsp_word.ready && $urandom_range(0, 5) == 0) begin
         stall = $urandom_range(1, 5);
         rsp_word.ready <= 1'b0;
         repeat (stall) @(posedge clock);
         rsp_word.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_word.valid && req_word.ready) || (rsp_word.valid && rsp_word.ready)
          || (!req_word.valid && pending_count == 0)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("svpwm_duty_generator: mismatch");
            $finish;
         end
      end
   end

   task automatic send_word(logic signed [15:0] volts, logic signed [31:0] angle);
      if (!calm_mode && $urandom_range(0, 4) == 0) begin
         req_word.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_word.valid           <= 1'b1;
      req_word.voltage_command <= volts;
      req_word.drive_angle     <= angle;
      do @(posedge clock); while (!req_word.ready);
   endtask

   task automatic settle();
      req_word.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DrainDelay) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CsrDataW-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_words(int count);
      logic signed [31:0] angle;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 3))
            0: angle = $urandom;
            1: angle = $urandom_range(0, 32'(TurnLen - 1));
            2: angle = 68629 * $urandom_range(0, 6) + $urandom_range(0, 4) - 2;
            default: angle = -$urandom_range(0, 32'(3 * TurnLen));
         endcase
         send_word(16'($urandom), angle);
      end
   endtask

   initial begin
      logic signed [31:0] corner_angles[12];
      corner_angles = '{0, 68628, 68629, 137258, 205887, 274516, 343145, 411773,
                        411774, -1, 32'sh7fffffff, 32'sh80000000};
      reset          = 1'b1;
      calm_mode      = 1'b0;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_SUPPLY_VOLTAGE;
      csr_wdata      = '0;
      req_word.valid = 1'b0;
      req_word.voltage_command = '0;
      req_word.drive_angle     = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (corner_angles[i]) begin
         send_word((i % 2) ? 16'sh7fff : 16'sh8000, corner_angles[i]);
      end
      send_word(16'sd3072, 32'sd100000);
      send_word(-16'sd3073, 32'sd300000);
      send_word(16'sd0, 32'sd5000);
      send_word(16'sd1500, -32'sd20000);
      random_words(100);
      settle();

      // tiny supply saturates duties, full period
      write_reg(CSR_SUPPLY_VOLTAGE, 16'd1);
      write_reg(CSR_VOLTAGE_LIMIT, 16'h7fff);
      write_reg(CSR_PWM_PERIOD, 16'hffff);
      random_words(120);
      settle();

      write_reg(CSR_SUPPLY_VOLTAGE, 16'h7fff);
      write_reg(CSR_VOLTAGE_LIMIT, 16'd0);
      write_reg(CSR_PWM_PERIOD, 16'd0);
      send_word(16'sd1, 32'sd1000);
      send_word(16'sd0, 32'sd1000);
      random_words(60);
      settle();

      write_reg(CSR_SUPPLY_VOLTAGE, 16'd0);
      write_reg(CSR_VOLTAGE_LIMIT, 16'd100);
      write_reg(CSR_PWM_PERIOD, 16'd1);
      random_words(60);
      settle();

      write_reg(CSR_SUPPLY_VOLTAGE, 16'h8000 | 16'd2500);
      write_reg(CSR_VOLTAGE_LIMIT, 16'h8000 | 16'd2000);
      write_reg(CSR_PWM_PERIOD, 16'd5000);
      write_reg(CSR_RESERVED, 16'd7);
      random_words(200);
      calm_mode <= 1'b1;
      random_words(150);
      settle();

      if (mismatch_count == 0) begin
         $display("svpwm_duty_generator: match");
      end else begin
         $display("svpwm_duty_generator: mismatch");
      end
      $finish;
   end

endmodule
